[sv/i2cee_pkg.sv]
// Package: shared types and constants for the I2C EEPROM byte access master
package i2cee_pkg;

	// Number of EEPROM address bytes sent (1 or 2)
	localparam int unsigned ADDR_BYTES = 2;

	// APB register map
	localparam int unsigned CFG_AW = 3;
	localparam logic REG_DEV_ADDR    = 1'b0;
	localparam logic REG_PHASE_TICKS = 1'b1;

	localparam logic [7:0]  DEV_ADDR_RST    = 8'd160;
	localparam logic [10:0] PHASE_TICKS_RST = 11'd1;
	localparam logic [10:0] PHASE_TICKS_MAX = 11'd1024;

	// Item kinds
	localparam logic KIND_TICK = 1'b0;
	localparam logic KIND_CMD  = 1'b1;

	// Transfer status codes
	localparam logic [1:0] STATUS_OK        = 2'd0;
	localparam logic [1:0] STATUS_DEV_NACK  = 2'd1;
	localparam logic [1:0] STATUS_ADDR_NACK = 2'd2;
	localparam logic [1:0] STATUS_DATA_NACK = 2'd3;

	// Byte steps of a transfer
	localparam logic [2:0] STEP_DEV_WR  = 3'd0;
	localparam logic [2:0] STEP_ADDR_HI = 3'd1;
	localparam logic [2:0] STEP_ADDR_LO = 3'd2;
	localparam logic [2:0] STEP_THIRD   = 3'd3;
	localparam logic [2:0] STEP_READ    = 3'd4;

	// Bus phases, one-hot
	typedef enum logic [15:0] {
		PH_IDLE      = 16'h0001,
		PH_START_A   = 16'h0002,
		PH_START_B   = 16'h0004,
		PH_START_C   = 16'h0008,
		PH_BIT_LOW   = 16'h0010,
		PH_BIT_HIGH  = 16'h0020,
		PH_ACK_LOW   = 16'h0040,
		PH_ACK_HIGH  = 16'h0080,
		PH_RD_LOW    = 16'h0100,
		PH_RD_HIGH   = 16'h0200,
		PH_NACK_LOW  = 16'h0400,
		PH_NACK_HIGH = 16'h0800,
		PH_STOP_A    = 16'h1000,
		PH_STOP_B    = 16'h2000,
		PH_STOP_C    = 16'h4000,
		PH_RESTART   = 16'h8000
	} phase_t;

	typedef struct packed {
		logic [7:0]  device_addr_byte;
		logic [10:0] phase_ticks;
	} cfg_t;

	typedef struct packed {
		logic        kind;
		logic        is_write;
		logic [15:0] mem_addr;
		logic [7:0]  wr_data;
		logic        sda_in;
	} item_t;

	typedef struct packed {
		logic       scl_out;
		logic       sda_pull_low;
		logic       busy_res;
		logic       done_res;
		logic [1:0] status;
		logic [7:0] read_data;
	} result_t;

endpackage

[sv/i2cee_if.sv]
// Interfaces: command/tick input channel and result output channel
interface i2cee_item_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic        is_write;
	logic [15:0] mem_addr;
	logic [7:0]  wr_data;
	logic        sda_in;

	modport source (output valid, kind, is_write, mem_addr, wr_data, sda_in, input ready);
	modport sink   (input valid, kind, is_write, mem_addr, wr_data, sda_in, output ready);
endinterface

interface i2cee_result_if;
	logic       valid;
	logic       ready;
	logic       scl_out;
	logic       sda_pull_low;
	logic       busy_res;
	logic       done_res;
	logic [1:0] status;
	logic [7:0] read_data;

	modport source (output valid, scl_out, sda_pull_low, busy_res, done_res, status, read_data,
		input ready);
	modport sink   (input valid, scl_out, sda_pull_low, busy_res, done_res, status, read_data,
		output ready);
endinterface

[sv/i2cee_cfg_regs.sv]
// APB configuration registers: device address byte and ticks per bus phase
module i2cee_cfg_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [i2cee_pkg::CFG_AW-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	output i2cee_pkg::cfg_t             cfg
);
	import i2cee_pkg::*;

	logic [7:0]  dev_addr_q;
	logic [10:0] phase_ticks_q;
	logic        wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_addr_q    <= DEV_ADDR_RST;
			phase_ticks_q <= PHASE_TICKS_RST;
		end else if (wr_en) begin
			unique case (paddr[2])
				REG_DEV_ADDR:    dev_addr_q    <= pwdata[7:0];
				REG_PHASE_TICKS: phase_ticks_q <= pwdata[10:0];
				default: ;
			endcase
		end
	end

	// read back
	always_comb begin
		unique case (paddr[2])
			REG_DEV_ADDR:    prdata = {24'd0, dev_addr_q};
			REG_PHASE_TICKS: prdata = {21'd0, phase_ticks_q};
			default:         prdata = 32'd0;
		endcase
	end

	assign cfg.device_addr_byte = dev_addr_q;
	assign cfg.phase_ticks      = phase_ticks_q;

endmodule

[sv/i2cee_seq.sv]
// Bus sequencer: phase state, bit/byte counters, held command and next result
module i2cee_seq (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  i2cee_pkg::item_t    item,
	input  i2cee_pkg::cfg_t     cfg,
	output logic                busy,
	output i2cee_pkg::result_t  result
);
	import i2cee_pkg::*;

	phase_t      phase_q, phase_n;
	logic [3:0]  bit_count_q, bit_count_n;
	logic [7:0]  shift_q, shift_n;
	logic [2:0]  step_q, step_n;
	logic [9:0]  timer_q, timer_n;
	logic [15:0] held_addr_q, held_addr_n;
	logic [7:0]  held_data_q, held_data_n;
	logic        held_write_q, held_write_n;
	logic [7:0]  last_read_q, last_read_n;
	logic [1:0]  status_q, status_n;
	logic        done;
	logic [10:0] ticks_eff;
	logic [10:0] timer_inc;
	logic [3:0]  bit_inc;
	logic [7:0]  rd_shift;

	assign busy = (phase_q != PH_IDLE);

	// clamp ticks per phase into 1..1024
	always_comb begin
		if (cfg.phase_ticks == 11'd0)
			ticks_eff = 11'd1;
		else if (cfg.phase_ticks > PHASE_TICKS_MAX)
			ticks_eff = PHASE_TICKS_MAX;
		else
			ticks_eff = cfg.phase_ticks;
	end

	assign timer_inc = {1'b0, timer_q} + 11'd1;
	assign bit_inc   = bit_count_q + 4'd1;
	assign rd_shift  = {shift_q[6:0], item.sda_in};

	// byte to send for a given step
	function automatic logic [7:0] step_byte(input logic [2:0] s);
		logic [7:0] b;
		case (s)
			STEP_DEV_WR:  b = cfg.device_addr_byte;
			STEP_ADDR_HI: b = held_addr_q[15:8];
			STEP_ADDR_LO: b = held_addr_q[7:0];
			STEP_THIRD:   b = held_write_q ? held_data_q : (cfg.device_addr_byte | 8'h01);
			default:      b = 8'h00;
		endcase
		return b;
	endfunction

	// next state
	always_comb begin
		phase_n      = phase_q;
		bit_count_n  = bit_count_q;
		shift_n      = shift_q;
		step_n       = step_q;
		timer_n      = timer_q;
		held_addr_n  = held_addr_q;
		held_data_n  = held_data_q;
		held_write_n = held_write_q;
		last_read_n  = last_read_q;
		status_n     = status_q;
		done         = 1'b0;

		if (item.kind == KIND_CMD) begin
			// a command is only taken when the bus is idle
			if (!busy) begin
				held_write_n = item.is_write;
				held_addr_n  = item.mem_addr;
				held_data_n  = item.wr_data;
				status_n     = STATUS_OK;
				step_n       = STEP_DEV_WR;
				bit_count_n  = 4'd0;
				shift_n      = 8'd0;
				timer_n      = 10'd0;
				phase_n      = PH_START_A;
			end
		end else if (busy) begin
			if (timer_inc >= ticks_eff) begin
				timer_n = 10'd0;
				unique case (phase_q)
					PH_START_A:  phase_n = PH_START_B;
					PH_START_B:  phase_n = PH_START_C;
					PH_START_C: begin
						shift_n     = step_byte(step_q);
						bit_count_n = 4'd0;
						phase_n     = PH_BIT_LOW;
					end
					PH_BIT_LOW:  phase_n = PH_BIT_HIGH;
					PH_BIT_HIGH: begin
						shift_n     = {shift_q[6:0], 1'b0};
						bit_count_n = bit_inc;
						phase_n     = (bit_inc >= 4'd8) ? PH_ACK_LOW : PH_BIT_LOW;
					end
					PH_ACK_LOW:  phase_n = PH_ACK_HIGH;
					PH_ACK_HIGH: begin
						if (item.sda_in) begin
							// slave NACK: blame the byte in flight and stop
							if (step_q == STEP_ADDR_HI || step_q == STEP_ADDR_LO)
								status_n = STATUS_ADDR_NACK;
							else if (step_q == STEP_THIRD && held_write_q)
								status_n = STATUS_DATA_NACK;
							else
								status_n = STATUS_DEV_NACK;
							phase_n = PH_STOP_A;
						end else begin
							case (step_q)
								STEP_DEV_WR: begin
									step_n      = (ADDR_BYTES >= 2) ? STEP_ADDR_HI : STEP_ADDR_LO;
									shift_n     = (ADDR_BYTES >= 2) ? held_addr_q[15:8]
										: held_addr_q[7:0];
									bit_count_n = 4'd0;
									phase_n     = PH_BIT_LOW;
								end
								STEP_ADDR_HI: begin
									step_n      = STEP_ADDR_LO;
									shift_n     = held_addr_q[7:0];
									bit_count_n = 4'd0;
									phase_n     = PH_BIT_LOW;
								end
								STEP_ADDR_LO: begin
									if (held_write_q) begin
										step_n      = STEP_THIRD;
										shift_n     = held_data_q;
										bit_count_n = 4'd0;
										phase_n     = PH_BIT_LOW;
									end else begin
										step_n  = STEP_THIRD;
										phase_n = PH_RESTART;
									end
								end
								STEP_THIRD: begin
									if (held_write_q) begin
										phase_n = PH_STOP_A;
									end else begin
										step_n      = STEP_READ;
										shift_n     = 8'd0;
										bit_count_n = 4'd0;
										phase_n     = PH_RD_LOW;
									end
								end
								default: phase_n = PH_STOP_A;
							endcase
						end
					end
					PH_RD_LOW:   phase_n = PH_RD_HIGH;
					PH_RD_HIGH: begin
						shift_n     = rd_shift;
						bit_count_n = bit_inc;
						if (bit_inc >= 4'd8) begin
							last_read_n = rd_shift;
							phase_n     = PH_NACK_LOW;
						end else begin
							phase_n = PH_RD_LOW;
						end
					end
					PH_NACK_LOW:  phase_n = PH_NACK_HIGH;
					PH_NACK_HIGH: phase_n = PH_STOP_A;
					PH_STOP_A:    phase_n = PH_STOP_B;
					PH_STOP_B:    phase_n = PH_STOP_C;
					PH_STOP_C: begin
						phase_n = PH_IDLE;
						done    = 1'b1;
					end
					PH_RESTART:   phase_n = PH_START_A;
					default:      phase_n = PH_IDLE;
				endcase
			end else begin
				timer_n = timer_inc[9:0];
			end
		end else begin
			phase_n = PH_IDLE;
		end
	end

	// line levels for the phase being entered
	always_comb begin
		result.scl_out      = 1'b1;
		result.sda_pull_low = 1'b0;
		unique case (phase_n)
			PH_START_B: begin
				result.scl_out      = 1'b1;
				result.sda_pull_low = 1'b1;
			end
			PH_START_C, PH_STOP_A: begin
				result.scl_out      = 1'b0;
				result.sda_pull_low = 1'b1;
			end
			PH_BIT_LOW: begin
				result.scl_out      = 1'b0;
				result.sda_pull_low = ~shift_n[7];
			end
			PH_BIT_HIGH: begin
				result.scl_out      = 1'b1;
				result.sda_pull_low = ~shift_n[7];
			end
			PH_ACK_LOW, PH_RD_LOW, PH_NACK_LOW, PH_RESTART: begin
				result.scl_out      = 1'b0;
				result.sda_pull_low = 1'b0;
			end
			PH_STOP_B: begin
				result.scl_out      = 1'b1;
				result.sda_pull_low = 1'b1;
			end
			default: begin
				result.scl_out      = 1'b1;
				result.sda_pull_low = 1'b0;
			end
		endcase
	end

	assign result.busy_res  = (phase_n != PH_IDLE);
	assign result.done_res  = done;
	assign result.status    = status_n;
	assign result.read_data = last_read_n;

	// state registers, updated on each accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			bit_count_q  <= 4'd0;
			shift_q      <= 8'd0;
			step_q       <= STEP_DEV_WR;
			timer_q      <= 10'd0;
			held_addr_q  <= 16'd0;
			held_data_q  <= 8'd0;
			held_write_q <= 1'b0;
			last_read_q  <= 8'd0;
			status_q     <= STATUS_OK;
		end else if (accept) begin
			phase_q      <= phase_n;
			bit_count_q  <= bit_count_n;
			shift_q      <= shift_n;
			step_q       <= step_n;
			timer_q      <= timer_n;
			held_addr_q  <= held_addr_n;
			held_data_q  <= held_data_n;
			held_write_q <= held_write_n;
			last_read_q  <= last_read_n;
			status_q     <= status_n;
		end
	end

endmodule

[sv/i2c_eeprom_byte_access_master.sv]
// Top level: I2C EEPROM byte write / random read master with APB configuration
//
//   port   role    carries
//   cmd    sink    one tick of time or one command (kind, is_write, mem_addr, wr_data, sda_in)
//   res    source  bus line levels, busy, done, status and last read byte per item
//   apb    slave   device_addr_byte at 0x0, phase_ticks at 0x4
//
// One result per item, registered and valid in the cycle after acceptance.
// An item is taken in every cycle while the result register is empty or being taken.
// A stalled result holds the register and blocks the next item until it is taken.
// arst_n clears the sequencer to idle with the bus released and sets reset register values.
module i2c_eeprom_byte_access_master (
	input  logic                         clk,
	input  logic                         arst_n,
	i2cee_item_if.sink                   cmd,
	i2cee_result_if.source               res,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [i2cee_pkg::CFG_AW-1:0] paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready
);
	import i2cee_pkg::*;

	cfg_t    cfg;
	item_t   item;
	result_t next_res;
	result_t res_q;
	logic    res_valid_q;
	logic    accept;
	logic    busy;

	i2cee_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign item.kind     = cmd.kind;
	assign item.is_write = cmd.is_write;
	assign item.mem_addr = cmd.mem_addr;
	assign item.wr_data  = cmd.wr_data;
	assign item.sda_in   = cmd.sda_in;

	assign cmd.ready = ~res_valid_q | res.ready;
	assign accept    = cmd.valid & cmd.ready;

	i2cee_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.item   (item),
		.cfg    (cfg),
		.busy   (busy),
		.result (next_res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (accept) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_q <= next_res;
		end
	end

	assign res.valid        = res_valid_q;
	assign res.scl_out      = res_q.scl_out;
	assign res.sda_pull_low = res_q.sda_pull_low;
	assign res.busy_res     = res_q.busy_res;
	assign res.done_res     = res_q.done_res;
	assign res.status       = res_q.status;
	assign res.read_data    = res_q.read_data;

`ifndef ASSERT_OFF
	// a finished transfer leaves the sequencer idle
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.done_res |-> !res.busy_res)
		else $error("done reported while still busy");

	// a command taken from idle starts a transfer with clean status
	a_cmd_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept && cmd.kind == KIND_CMD && !busy
		|=> res.valid && res.busy_res && res.status == STATUS_OK && busy)
		else $error("command from idle did not start a transfer");

	// idle ticks keep the bus released
	a_idle_release: assert property (@(posedge clk) disable iff (!arst_n)
		accept && cmd.kind == KIND_TICK && !busy
		|=> res.scl_out && !res.sda_pull_low && !res.busy_res && !res.done_res)
		else $error("bus not released while idle");
`endif

endmodule

[test/i2c_eeprom_byte_access_master_tb.sv]
// Testbench for the I2C EEPROM byte access master: self-checking against a bus-phase predictor
module i2c_eeprom_byte_access_master_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import i2cee_pkg::*;

	// Bus phases of a whole transfer at one tick per phase
	localparam int WR_PHASES      = 78;
	localparam int RD_PHASES      = 100;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int LONG_HOLD      = 400;

	// How the simulated EEPROM answers on the ACK slots
	typedef enum logic [1:0] {
		SLAVE_RAW,
		SLAVE_ACK,
		SLAVE_NACK_AT
	} slave_t;

	typedef struct {
		item_t      item;
		slave_t     slave;
		logic [2:0] nack_step;
	} stim_t;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [CFG_AW-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	i2cee_item_if   cmd_ch();
	i2cee_result_if res_ch();

	i2c_eeprom_byte_access_master dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd_ch),
		.res     (res_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// Predictor state and configuration
	logic [7:0]  dev_byte     = DEV_ADDR_RST;
	logic [10:0] phase_len    = PHASE_TICKS_RST;
	phase_t      bus_phase    = PH_IDLE;
	logic [3:0]  bit_num      = '0;
	logic [7:0]  shift_reg    = '0;
	logic [2:0]  xfer_step    = STEP_DEV_WR;
	int unsigned phase_count  = 0;
	logic [15:0] cmd_addr     = '0;
	logic [7:0]  cmd_data     = '0;
	logic        cmd_is_write = 1'b0;
	logic [7:0]  rd_byte      = '0;
	logic [1:0]  xfer_status  = STATUS_OK;

	// Stimulus and scoreboard
	stim_t   pending_items[$];
	result_t predicted_results[$];
	stim_t   next_entry;
	logic    next_sda;
	int      items_queued   = 0;
	int      items_accepted = 0;
	int      mismatches     = 0;
	int      quiet_cycles   = 0;
	int      send_gap       = 0;
	int      recv_stall     = 0;
	int      hold_asks      = 0;
	int      hold_served    = 0;
	bit      item_taken     = 1'b0;
	bit      sender_idle_on = 1'b1;
	bit      recv_idle_on   = 1'b1;

	// Clock
	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	function automatic int unsigned eff_phase_len();
		if (phase_len == 0)
			return 1;
		if (phase_len > PHASE_TICKS_MAX)
			return PHASE_TICKS_MAX;
		return phase_len;
	endfunction

	function automatic logic [7:0] byte_of_step(logic [2:0] s);
		case (s)
			STEP_DEV_WR:  return dev_byte;
			STEP_ADDR_HI: return cmd_addr[15:8];
			STEP_ADDR_LO: return cmd_addr[7:0];
			STEP_THIRD:   return cmd_is_write ? cmd_data : (dev_byte | 8'h01);
			default:      return 8'h00;
		endcase
	endfunction

	function automatic void load_byte(logic [2:0] s);
		xfer_step = s;
		shift_reg = byte_of_step(s);
		bit_num   = '0;
		bus_phase = PH_BIT_LOW;
	endfunction

	// Acknowledge slot: NACK aborts to STOP, ACK moves to the next byte
	function automatic void take_ack(logic sda);
		if (sda) begin
			if (xfer_step == STEP_ADDR_HI || xfer_step == STEP_ADDR_LO)
				xfer_status = STATUS_ADDR_NACK;
			else if (xfer_step == STEP_THIRD && cmd_is_write)
				xfer_status = STATUS_DATA_NACK;
			else
				xfer_status = STATUS_DEV_NACK;
			bus_phase = PH_STOP_A;
		end else begin
			case (xfer_step)
				STEP_DEV_WR: load_byte(ADDR_BYTES >= 2 ? STEP_ADDR_HI : STEP_ADDR_LO);
				STEP_ADDR_HI: load_byte(STEP_ADDR_LO);
				STEP_ADDR_LO: begin
					if (cmd_is_write) begin
						load_byte(STEP_THIRD);
					end else begin
						xfer_step = STEP_THIRD;
						bus_phase = PH_RESTART;
					end
				end
				STEP_THIRD: begin
					if (cmd_is_write) begin
						bus_phase = PH_STOP_A;
					end else begin
						xfer_step = STEP_READ;
						shift_reg = '0;
						bit_num   = '0;
						bus_phase = PH_RD_LOW;
					end
				end
				default: bus_phase = PH_STOP_A;
			endcase
		end
	endfunction

	// End of one bus phase; returns 1 when the final STOP completes
	function automatic logic advance_phase(logic sda);
		case (bus_phase)
			PH_START_A:   bus_phase = PH_START_B;
			PH_START_B:   bus_phase = PH_START_C;
			PH_START_C:   load_byte(xfer_step);
			PH_BIT_LOW:   bus_phase = PH_BIT_HIGH;
			PH_BIT_HIGH: begin
				shift_reg = shift_reg << 1;
				bit_num   = bit_num + 4'd1;
				if (bit_num >= 8)
					bus_phase = PH_ACK_LOW;
				else
					bus_phase = PH_BIT_LOW;
			end
			PH_ACK_LOW:   bus_phase = PH_ACK_HIGH;
			PH_ACK_HIGH:  take_ack(sda);
			PH_RD_LOW:    bus_phase = PH_RD_HIGH;
			PH_RD_HIGH: begin
				shift_reg = {shift_reg[6:0], sda};
				bit_num   = bit_num + 4'd1;
				if (bit_num >= 8) begin
					rd_byte   = shift_reg;
					bus_phase = PH_NACK_LOW;
				end else begin
					bus_phase = PH_RD_LOW;
				end
			end
			PH_NACK_LOW:  bus_phase = PH_NACK_HIGH;
			PH_NACK_HIGH: bus_phase = PH_STOP_A;
			PH_STOP_A:    bus_phase = PH_STOP_B;
			PH_STOP_B:    bus_phase = PH_STOP_C;
			PH_STOP_C: begin
				bus_phase = PH_IDLE;
				return 1'b1;
			end
			PH_RESTART:   bus_phase = PH_START_A;
			default:      bus_phase = PH_IDLE;
		endcase
		return 1'b0;
	endfunction

	// Expected line levels and status after one accepted transaction
	function automatic result_t predict_bus_result(item_t it);
		result_t r;
		logic    fin;
		fin = 1'b0;
		if (it.kind == KIND_CMD) begin
			if (bus_phase == PH_IDLE) begin
				cmd_is_write = it.is_write;
				cmd_addr     = it.mem_addr;
				cmd_data     = it.wr_data;
				xfer_status  = STATUS_OK;
				xfer_step    = STEP_DEV_WR;
				bit_num      = '0;
				shift_reg    = '0;
				phase_count  = 0;
				bus_phase    = PH_START_A;
			end
		end else if (bus_phase != PH_IDLE) begin
			if (phase_count + 1 >= eff_phase_len()) begin
				phase_count = 0;
				fin = advance_phase(it.sda_in);
			end else begin
				phase_count = phase_count + 1;
			end
		end
		r.scl_out      = 1'b1;
		r.sda_pull_low = 1'b0;
		case (bus_phase)
			PH_START_B: r.sda_pull_low = 1'b1;
			PH_START_C: begin
				r.scl_out      = 1'b0;
				r.sda_pull_low = 1'b1;
			end
			PH_BIT_LOW: begin
				r.scl_out      = 1'b0;
				r.sda_pull_low = ~shift_reg[7];
			end
			PH_BIT_HIGH: r.sda_pull_low = ~shift_reg[7];
			PH_ACK_LOW, PH_RD_LOW, PH_NACK_LOW, PH_RESTART: r.scl_out = 1'b0;
			PH_STOP_A: begin
				r.scl_out      = 1'b0;
				r.sda_pull_low = 1'b1;
			end
			PH_STOP_B: r.sda_pull_low = 1'b1;
			default: ;
		endcase
		r.busy_res  = (bus_phase != PH_IDLE);
		r.done_res  = fin;
		r.status    = xfer_status;
		r.read_data = rd_byte;
		return r;
	endfunction

	function automatic void check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatches++;
		end
	endfunction

	// Item driver: holds each transaction until taken, answers ACK slots as told
	always @(negedge clk) begin
		if (arst_n && (!cmd_ch.valid || item_taken)) begin
			if (send_gap > 0) begin
				send_gap--;
				cmd_ch.valid <= 1'b0;
			end else if (pending_items.size() == 0) begin
				cmd_ch.valid <= 1'b0;
			end else if (sender_idle_on && $urandom_range(0, 5) == 0) begin
				send_gap = $urandom_range(0, 11);
				cmd_ch.valid <= 1'b0;
			end else begin
				next_entry = pending_items.pop_front();
				next_sda   = next_entry.item.sda_in;
				if (next_entry.item.kind == KIND_TICK && bus_phase == PH_ACK_HIGH) begin
					if (next_entry.slave == SLAVE_ACK)
						next_sda = 1'b0;
					else if (next_entry.slave == SLAVE_NACK_AT)
						next_sda = (xfer_step == next_entry.nack_step);
				end
				cmd_ch.kind     <= next_entry.item.kind;
				cmd_ch.is_write <= next_entry.item.is_write;
				cmd_ch.mem_addr <= next_entry.item.mem_addr;
				cmd_ch.wr_data  <= next_entry.item.wr_data;
				cmd_ch.sda_in   <= next_sda;
				cmd_ch.valid    <= 1'b1;
			end
		end
	end

	// Result receiver: random stall bursts plus long hold-offs on request
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_served != hold_asks) begin
				hold_served++;
				recv_stall = LONG_HOLD - 1;
				res_ch.ready <= 1'b0;
			end else if (recv_stall > 0) begin
				recv_stall--;
				res_ch.ready <= 1'b0;
			end else if (recv_idle_on && $urandom_range(0, 7) == 0) begin
				recv_stall = $urandom_range(0, 11);
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	// Predict on each accepted item, check each accepted result
	always @(posedge clk) begin
		item_t seen;
		result_t want;
		if (arst_n) begin
			item_taken = cmd_ch.valid && cmd_ch.ready;
			if (item_taken) begin
				seen.kind     = cmd_ch.kind;
				seen.is_write = cmd_ch.is_write;
				seen.mem_addr = cmd_ch.mem_addr;
				seen.wr_data  = cmd_ch.wr_data;
				seen.sda_in   = cmd_ch.sda_in;
				predicted_results.push_back(predict_bus_result(seen));
				items_accepted++;
			end
			if (res_ch.valid && res_ch.ready) begin
				if (predicted_results.size() == 0) begin
					$error("result transaction with no expectation waiting");
					mismatches++;
				end else begin
					want = predicted_results.pop_front();
					check_field("scl_out", want.scl_out, res_ch.scl_out);
					check_field("sda_pull_low", want.sda_pull_low, res_ch.sda_pull_low);
					check_field("busy_res", want.busy_res, res_ch.busy_res);
					check_field("done_res", want.done_res, res_ch.done_res);
					check_field("status", want.status, res_ch.status);
					check_field("read_data", want.read_data, res_ch.read_data);
				end
			end
		end
	end

	// Watchdog on cycles with no transaction on either channel
	always @(posedge clk) begin
		if (arst_n) begin
			if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	task automatic push_entry(item_t it, slave_t s, logic [2:0] ns);
		stim_t e;
		e.item      = it;
		e.slave     = s;
		e.nack_step = ns;
		pending_items.push_back(e);
		items_queued++;
	endtask

	task automatic push_command(logic wr, logic [15:0] addr, logic [7:0] data);
		item_t it;
		it.kind     = KIND_CMD;
		it.is_write = wr;
		it.mem_addr = addr;
		it.wr_data  = data;
		it.sda_in   = 1'($urandom_range(0, 1));
		push_entry(it, SLAVE_RAW, STEP_DEV_WR);
	endtask

	// Tick items; one_pct is the chance in percent of SDA sampled high
	task automatic queue_ticks(int n, int one_pct, slave_t s, logic [2:0] ns);
		item_t it;
		for (int i = 0; i < n; i++) begin
			it.kind     = KIND_TICK;
			it.is_write = 1'($urandom_range(0, 1));
			it.mem_addr = 16'($urandom);
			it.wr_data  = 8'($urandom);
			it.sda_in   = ($urandom_range(0, 99) < one_pct);
			push_entry(it, s, ns);
		end
	endtask

	// One command with its ticks; stray_at >= 0 slips in a second command after that many ticks
	task automatic queue_transfer(logic wr, logic [15:0] addr, logic [7:0] data, slave_t s,
		logic [2:0] ns, int phases, int one_pct, int stray_at);
		int total;
		total = phases * int'(eff_phase_len());
		push_command(wr, addr, data);
		if (stray_at >= 0 && stray_at < total) begin
			queue_ticks(stray_at, one_pct, s, ns);
			push_command(1'($urandom), 16'($urandom), 8'($urandom));
			queue_ticks(total - stray_at, one_pct, s, ns);
		end else begin
			queue_ticks(total, one_pct, s, ns);
		end
	endtask

	// Wait until everything queued has been taken and checked, and the bus is idle
	task automatic settle();
		do begin
			while (items_accepted != items_queued || predicted_results.size() != 0)
				@(negedge clk);
			if (bus_phase != PH_IDLE)
				queue_ticks(16, 0, SLAVE_ACK, STEP_DEV_WR);
		end while (bus_phase != PH_IDLE);
		repeat (2) @(negedge clk);
	endtask

	// APB write: setup cycle then access cycle
	task automatic cfg_write(logic idx, logic [31:0] value);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (idx == REG_DEV_ADDR)
			dev_byte = value[7:0];
		else
			phase_len = value[10:0];
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// Random transfers: mostly well-formed, some NACKed, some cut short or noisy
	task automatic random_transfers(int budget);
		int      start;
		int      pick;
		int      full;
		int      stray;
		logic    wr;
		start = items_queued;
		while (items_queued - start < budget) begin
			wr    = 1'($urandom_range(0, 1));
			full  = (wr ? WR_PHASES : RD_PHASES) + 2;
			pick  = $urandom_range(0, 9);
			stray = ($urandom_range(0, 7) == 0) ? $urandom_range(0, full) : -1;
			if (pick < 7)
				queue_transfer(wr, 16'($urandom), 8'($urandom), SLAVE_ACK, STEP_DEV_WR,
					full, 50, stray);
			else if (pick == 7)
				queue_transfer(wr, 16'($urandom), 8'($urandom), SLAVE_NACK_AT,
					3'($urandom_range(0, 3)), full, 50, stray);
			else
				queue_transfer(wr, 16'($urandom), 8'($urandom), SLAVE_RAW, STEP_DEV_WR,
					$urandom_range(4, full), 15, stray);
			if ($urandom_range(0, 9) == 0)
				queue_ticks($urandom_range(1, 4), 50, SLAVE_RAW, STEP_DEV_WR);
		end
	endtask

	initial begin
		arst_n          = 1'b0;
		psel            = 1'b0;
		penable         = 1'b0;
		pwrite          = 1'b0;
		paddr           = '0;
		pwdata          = '0;
		cmd_ch.valid    = 1'b0;
		cmd_ch.kind     = KIND_TICK;
		cmd_ch.is_write = 1'b0;
		cmd_ch.mem_addr = '0;
		cmd_ch.wr_data  = '0;
		cmd_ch.sda_in   = 1'b0;
		res_ch.ready    = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: idle ticks, field extremes, read of all ones and all zeros
		queue_ticks(2, 50, SLAVE_RAW, STEP_DEV_WR);
		queue_transfer(1'b1, 16'hFFFF, 8'hFF, SLAVE_ACK, STEP_DEV_WR, WR_PHASES + 2, 50, -1);
		queue_transfer(1'b0, 16'h0000, 8'h00, SLAVE_ACK, STEP_DEV_WR, RD_PHASES + 2, 100, -1);
		queue_transfer(1'b0, 16'hFFFF, 8'hFF, SLAVE_ACK, STEP_DEV_WR, RD_PHASES + 2, 0, -1);
		// Command arriving mid-transfer is ignored
		queue_transfer(1'b1, 16'h0000, 8'h00, SLAVE_ACK, STEP_DEV_WR, WR_PHASES + 2, 50, 10);
		// NACK on each byte of a write, then on the device read byte
		queue_transfer(1'b1, 16'h1234, 8'h5A, SLAVE_NACK_AT, STEP_DEV_WR, WR_PHASES, 50, -1);
		queue_transfer(1'b1, 16'h8001, 8'hA5, SLAVE_NACK_AT, STEP_ADDR_HI, WR_PHASES, 50, -1);
		queue_transfer(1'b1, 16'h7FFE, 8'h3C, SLAVE_NACK_AT, STEP_ADDR_LO, WR_PHASES, 50, -1);
		queue_transfer(1'b1, 16'hC3C3, 8'h81, SLAVE_NACK_AT, STEP_THIRD, WR_PHASES, 50, -1);
		queue_transfer(1'b0, 16'h0F0F, 8'h00, SLAVE_NACK_AT, STEP_THIRD, RD_PHASES, 50, -1);
		// Two commands back to back: the second is dropped
		queue_transfer(1'b0, 16'hAAAA, 8'h55, SLAVE_ACK, STEP_DEV_WR, RD_PHASES + 2, 50, 0);
		settle();

		// Configuration extremes: zero phase length acts as one, multi-tick phases
		cfg_write(REG_DEV_ADDR, 32'd0);
		cfg_write(REG_PHASE_TICKS, 32'd0);
		queue_transfer(1'b1, 16'h5555, 8'hAA, SLAVE_ACK, STEP_DEV_WR, WR_PHASES + 2, 50, -1);
		settle();
		cfg_write(REG_DEV_ADDR, 32'd254);
		cfg_write(REG_PHASE_TICKS, 32'd3);
		queue_transfer(1'b1, 16'h00FF, 8'h0F, SLAVE_NACK_AT, STEP_DEV_WR, 25, 50, -1);
		settle();

		// Random: unit phases with idling and one long receiver hold-off
		cfg_write(REG_DEV_ADDR, $urandom_range(0, 254));
		cfg_write(REG_PHASE_TICKS, 32'd1);
		random_transfers(100);
		hold_asks++;
		settle();

		// Random: two ticks per phase
		cfg_write(REG_DEV_ADDR, $urandom_range(0, 254));
		cfg_write(REG_PHASE_TICKS, 32'd2);
		random_transfers(60);
		settle();

		// Random: full rate, no idling on either side
		cfg_write(REG_DEV_ADDR, DEV_ADDR_RST);
		cfg_write(REG_PHASE_TICKS, 32'd1);
		sender_idle_on = 1'b0;
		recv_idle_on   = 1'b0;
		random_transfers(80);
		settle();
		repeat (4) @(posedge clk);

		if (mismatches == 0 && predicted_results.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
